// File: rtl/mtcls_pkg.sv
package mtcls_pkg;

    localparam int CELL_W       = 16;
    localparam int SUM_W        = 17;
    localparam int WSUM_W       = 18;
    localparam int POS_W        = 6;
    localparam int CFG_W        = 7;
    localparam int WIN_LEN      = 3;
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [CFG_W-1:0] COLS_RESET = 7'd64;

    localparam logic DIR_HORIZ = 1'b0;
    localparam logic DIR_VERT  = 1'b1;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic                     last_cell;
    } cell_t;

    typedef struct packed {
        logic [SUM_W-1:0] best_sum;
        logic [POS_W-1:0] best_row;
        logic [POS_W-1:0] best_col;
        logic             best_direction;
        logic             found;
    } result_t;

    // line store access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ls_ctrl_t;

    // tracker strobes for the transaction in the compute stage
    typedef struct packed {
        logic fire;
        logic clear;
        logic h_ok;
        logic v_ok;
    } trk_ctrl_t;

    function automatic logic signed [WSUM_W-1:0] sum3(
        input logic signed [CELL_W-1:0] a,
        input logic signed [CELL_W-1:0] b,
        input logic signed [CELL_W-1:0] c
    );
        logic signed [WSUM_W-1:0] ea;
        logic signed [WSUM_W-1:0] eb;
        logic signed [WSUM_W-1:0] ec;
        ea = WSUM_W'(a);
        eb = WSUM_W'(b);
        ec = WSUM_W'(c);
        return ea + eb + ec;
    endfunction

endpackage

// File: rtl/mtcls_line_store.sv
module mtcls_line_store #(
    parameter int DEPTH = mtcls_pkg::DEF_MAX_COLS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mtcls_pkg::ls_ctrl_t               ctrl,
    input  logic [AW-1:0]                     rd_addr,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [mtcls_pkg::CELL_W-1:0] wr_value,
    output logic signed [mtcls_pkg::CELL_W-1:0] above_1,
    output logic signed [mtcls_pkg::CELL_W-1:0] above_2
);
    import mtcls_pkg::*;

    // store a: one row up, store b: two rows up
    logic [CELL_W-1:0] mem_a [DEPTH];
    logic [CELL_W-1:0] mem_b [DEPTH];

    logic [CELL_W-1:0] rd_a_reg;
    logic [CELL_W-1:0] rd_b_reg;
    logic              fwd_valid_reg;
    logic [CELL_W-1:0] fwd_a_reg;
    logic [CELL_W-1:0] fwd_b_reg;

    always_comb
    begin
        above_1 = fwd_valid_reg ? fwd_a_reg : rd_a_reg;
        above_2 = fwd_valid_reg ? fwd_b_reg : rd_b_reg;
    end

    // write back: shift the column down one row
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem_a[wr_addr] <= wr_value;
            mem_b[wr_addr] <= above_1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rd_a_reg  <= mem_a[rd_addr];
            rd_b_reg  <= mem_b[rd_addr];
            fwd_a_reg <= wr_value;
            fwd_b_reg <= above_1;
        end
    end

    // read and write of the same column at one edge: take the written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (ctrl.rd_en)
            fwd_valid_reg <= ctrl.wr_en && (wr_addr == rd_addr);
    end

endmodule

// File: rtl/mtcls_tracker.sv
module mtcls_tracker #(
    parameter int RW = 6,
    parameter int CW = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mtcls_pkg::trk_ctrl_t               ctrl,
    input  logic signed [mtcls_pkg::WSUM_W-1:0] h_sum,
    input  logic [RW-1:0]                      h_row,
    input  logic [CW-1:0]                      h_col,
    input  logic signed [mtcls_pkg::WSUM_W-1:0] v_sum,
    input  logic [RW-1:0]                      v_row,
    input  logic [CW-1:0]                      v_col,
    output mtcls_pkg::result_t                 result
);
    import mtcls_pkg::*;

    localparam int KW = RW + CW + 1;

    logic [SUM_W-1:0] best_sum_reg;
    logic [KW-1:0]    best_key_reg;
    logic             found_reg;

    logic [SUM_W-1:0] sum_1;
    logic [KW-1:0]    key_1;
    logic             found_1;
    logic [SUM_W-1:0] sum_next;
    logic [KW-1:0]    key_next;
    logic             found_next;
    logic [KW-1:0]    h_key;
    logic [KW-1:0]    v_key;
    logic             h_take;
    logic             v_take;
    logic [RW+POS_W-1:0] row_wide;
    logic [CW+POS_W-1:0] col_wide;

    // key order: row, then column, then horizontal before vertical
    assign h_key = {h_row, h_col, DIR_HORIZ};
    assign v_key = {v_row, v_col, DIR_VERT};

    always_comb
    begin
        h_take = ctrl.h_ok && !h_sum[WSUM_W-1] && (h_sum != '0) &&
                 (!found_reg || (h_sum[SUM_W-1:0] > best_sum_reg) ||
                  ((h_sum[SUM_W-1:0] == best_sum_reg) && (h_key < best_key_reg)));
        sum_1   = h_take ? h_sum[SUM_W-1:0] : best_sum_reg;
        key_1   = h_take ? h_key : best_key_reg;
        found_1 = found_reg || h_take;

        v_take = ctrl.v_ok && !v_sum[WSUM_W-1] && (v_sum != '0) &&
                 (!found_1 || (v_sum[SUM_W-1:0] > sum_1) ||
                  ((v_sum[SUM_W-1:0] == sum_1) && (v_key < key_1)));
        sum_next   = v_take ? v_sum[SUM_W-1:0] : sum_1;
        key_next   = v_take ? v_key : key_1;
        found_next = found_1 || v_take;
    end

    always_comb
    begin
        row_wide = {{POS_W{1'b0}}, key_next[KW-1 -: RW]};
        col_wide = {{POS_W{1'b0}}, key_next[CW:1]};
        result   = '0;
        if (found_next)
        begin
            result.best_sum       = sum_next;
            result.best_row       = row_wide[POS_W-1:0];
            result.best_col       = col_wide[POS_W-1:0];
            result.best_direction = key_next[0];
            result.found          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_sum_reg <= '0;
            best_key_reg <= '1;
            found_reg    <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            if (ctrl.clear)
            begin
                best_sum_reg <= '0;
                best_key_reg <= '1;
                found_reg    <= 1'b0;
            end
            else
            begin
                best_sum_reg <= sum_next;
                best_key_reg <= key_next;
                found_reg    <= found_next;
            end
        end
    end

endmodule

// File: rtl/max_three_cell_line_sum_finder.sv
// Finds the largest sum of three horizontally or vertically adjacent cells in a
// matrix streamed in raster order, one signed 16-bit cell per transaction, with
// last_cell set on the final cell. Only sums above zero count; on equal sums the
// window starting at the lowest row, then lowest column, wins, horizontal before
// vertical. The transaction carrying last_cell produces exactly one result
// transaction (found=0 and all fields zero when nothing qualified) and clears
// the tracker. One cell is taken every clock cycle; the only stall comes from a
// result that is still waiting in the output register when the next last cell
// reaches the compute stage. The result is registered as the last cell leaves
// the compute stage. The rate is set by the two column line stores: each is
// read at accept, written back as its cell leaves the compute stage, with a
// forward path for back-to-back hits on one column (a one-column matrix).
// column_count (write with column_count_we) is sampled per cell; 0 acts as 1 and
// values above MAX_COLS act as MAX_COLS. Rows past MAX_ROWS without a last cell
// are dropped. Line stores are not cleared; the first two rows never use them.
module max_three_cell_line_sum_finder #(
    parameter int MAX_COLS = mtcls_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mtcls_pkg::DEF_MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cell_valid,
    output logic                          cell_ready,
    input  mtcls_pkg::cell_t              cell_data,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mtcls_pkg::result_t            result,
    input  logic                          column_count_we,
    input  logic [mtcls_pkg::CFG_W-1:0]   column_count_data
);
    import mtcls_pkg::*;

    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;   // column index
    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;   // row of a window
    localparam int RCW  = $clog2(MAX_ROWS + 1);                    // row counter
    localparam int CCW  = $clog2(MAX_COLS + 1);
    localparam int EW   = ((CCW > CFG_W) ? CCW : CFG_W) + 1;       // column compare width

    localparam logic [EW-1:0]  MAX_COLS_E = EW'(MAX_COLS);
    localparam logic [RCW-1:0] MAX_ROWS_R = RCW'(MAX_ROWS);
    localparam logic [CW-1:0]  WIN_C      = CW'(WIN_LEN - 1);
    localparam logic [RW-1:0]  WIN_R      = RW'(WIN_LEN - 1);

    // configuration
    logic [CFG_W-1:0] column_count_reg;

    // position of the next cell and the two cells before it
    logic [CW-1:0]           col_index_reg;
    logic [RCW-1:0]          row_index_reg;
    logic signed [CELL_W-1:0] prev_1_reg;
    logic signed [CELL_W-1:0] prev_2_reg;

    // compute stage
    logic                     s1_valid_reg;
    logic                     s1_last_reg;
    logic                     s1_wr_reg;
    logic                     s1_h_reg;
    logic                     s1_v_reg;
    logic signed [CELL_W-1:0] s1_value_reg;
    logic signed [CELL_W-1:0] s1_prev_1_reg;
    logic signed [CELL_W-1:0] s1_prev_2_reg;
    logic [RW-1:0]            s1_row_reg;
    logic [CW-1:0]            s1_col_reg;

    // output register
    logic    result_valid_reg;
    result_t result_reg;

    logic                     accept;
    logic                     s1_go;
    logic                     in_range;
    logic                     row_end;
    logic [EW-1:0]            cols_raw;
    logic [EW-1:0]            cols_eff;
    logic [EW-1:0]            col_plus;
    logic signed [CELL_W-1:0] above_1;
    logic signed [CELL_W-1:0] above_2;
    logic signed [WSUM_W-1:0] h_sum;
    logic signed [WSUM_W-1:0] v_sum;
    ls_ctrl_t                 ls_ctrl;
    trk_ctrl_t                trk_ctrl;
    result_t                  trk_result;

    // a last cell may leave the compute stage only when the output slot frees
    assign s1_go      = s1_valid_reg && (!s1_last_reg || !result_valid_reg || result_ready);
    assign cell_ready = !s1_valid_reg || s1_go;
    assign accept     = cell_valid && cell_ready;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // effective column count and end-of-row test
    always_comb
    begin
        cols_raw = EW'(column_count_reg);
        priority if (cols_raw == '0)
            cols_eff = EW'(1);
        else if (cols_raw > MAX_COLS_E)
            cols_eff = MAX_COLS_E;
        else
            cols_eff = cols_raw;
        col_plus = EW'(col_index_reg) + EW'(1);
        row_end  = (col_plus >= cols_eff);
        in_range = (row_index_reg < MAX_ROWS_R);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            column_count_reg <= COLS_RESET;
        else if (column_count_we)
            column_count_reg <= column_count_data;
    end

    // position tracking and the horizontal window history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_index_reg <= '0;
            row_index_reg <= '0;
            prev_1_reg    <= '0;
            prev_2_reg    <= '0;
        end
        else if (accept)
        begin
            if (in_range)
            begin
                prev_1_reg <= cell_data.cell_value;
                prev_2_reg <= prev_1_reg;
            end
            if (cell_data.last_cell)
            begin
                col_index_reg <= '0;
                row_index_reg <= '0;
            end
            else if (in_range)
            begin
                if (row_end)
                begin
                    col_index_reg <= '0;
                    row_index_reg <= row_index_reg + RCW'(1);
                end
                else
                begin
                    col_index_reg <= col_index_reg + CW'(1);
                end
            end
        end
    end

    // compute stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    // compute stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg   <= cell_data.last_cell;
            s1_wr_reg     <= in_range;
            s1_h_reg      <= in_range && (col_index_reg >= WIN_C);
            s1_v_reg      <= in_range && (row_index_reg >= RCW'(WIN_LEN - 1));
            s1_value_reg  <= cell_data.cell_value;
            s1_prev_1_reg <= prev_1_reg;
            s1_prev_2_reg <= prev_2_reg;
            s1_row_reg    <= row_index_reg[RW-1:0];
            s1_col_reg    <= col_index_reg;
        end
    end

    assign ls_ctrl.rd_en = accept;
    assign ls_ctrl.wr_en = s1_go && s1_wr_reg;

    mtcls_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ls_ctrl),
        .rd_addr  (col_index_reg),
        .wr_addr  (s1_col_reg),
        .wr_value (s1_value_reg),
        .above_1  (above_1),
        .above_2  (above_2)
    );

    assign h_sum = sum3(s1_prev_2_reg, s1_prev_1_reg, s1_value_reg);
    assign v_sum = sum3(above_2, above_1, s1_value_reg);

    assign trk_ctrl.fire  = s1_go;
    assign trk_ctrl.clear = s1_last_reg;
    assign trk_ctrl.h_ok  = s1_h_reg;
    assign trk_ctrl.v_ok  = s1_v_reg;

    mtcls_tracker #(
        .RW (RW),
        .CW (CW)
    ) u_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (trk_ctrl),
        .h_sum  (h_sum),
        .h_row  (s1_row_reg),
        .h_col  (s1_col_reg - WIN_C),
        .v_sum  (v_sum),
        .v_row  (s1_row_reg - WIN_R),
        .v_col  (s1_col_reg),
        .result (trk_result)
    );

    // result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s1_go && s1_last_reg)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
            result_reg <= trk_result;
    end

endmodule
